[rtl/core/rtg_pkg.sv]
// Shared types, constants and coefficient tables for the RGB to gray converter.
package rtg_pkg;

  // Widths of the pixel channels and of the gray result.
  localparam int unsigned ChanW = 8;
  localparam int unsigned LumaW = 17;
  localparam int unsigned ModeW = 4;

  // Numerator ahead of the divide by 255, which is also the width of the square root.
  localparam int unsigned NumW  = 25;
  // Sum of squares of three channels.
  localparam int unsigned RadW  = 18;
  // Partial remainder of the square root.
  localparam int unsigned RemW  = NumW + 2;
  // One root bit per cell.
  localparam int unsigned NumCells = NumW;
  // Width of a product of one channel and one coefficient.
  localparam int unsigned ProdW = 24;
  localparam int unsigned CoefW = 16;

  // Register codes for the gray mode.
  typedef enum logic [ModeW-1:0] {
    MODE_AVERAGE   = 4'd0,
    MODE_BT2020    = 4'd1,
    MODE_BT709     = 4'd2,
    MODE_BT601     = 4'd3,
    MODE_HSL       = 4'd4,
    MODE_EUCLIDEAN = 4'd5,
    MODE_RED       = 4'd6,
    MODE_GREEN     = 4'd7,
    MODE_BLUE      = 4'd8
  } gray_mode_e;

  // How the numerator is formed from the first stage's results.
  typedef enum logic [2:0] {
    KIND_AVG,
    KIND_WSUM,
    KIND_SQRT,
    KIND_HSL,
    KIND_CHAN
  } luma_kind_e;

  // Data that travels along the square-root cells.
  typedef struct packed {
    logic            is_sqrt;
    logic [RadW-1:0] rad;
    logic [RemW-1:0] rem;
    logic [NumW-1:0] root;
  } cell_t;

  // Luma weights in Q0.16; each set sums to exactly one.
  function automatic logic [CoefW-1:0] weight(input logic [ModeW-1:0] mode,
                                              input logic [1:0] chan);
    logic [CoefW-1:0] w;
    begin
      w = '0;
      case (mode)
        MODE_BT2020: begin
          case (chan)
            2'd0:    w = 16'd17216;
            2'd1:    w = 16'd44434;
            default: w = 16'd3886;
          endcase
        end
        MODE_BT709: begin
          case (chan)
            2'd0:    w = 16'd13933;
            2'd1:    w = 16'd46871;
            default: w = 16'd4732;
          endcase
        end
        default: begin
          case (chan)
            2'd0:    w = 16'd19595;
            2'd1:    w = 16'd38470;
            default: w = 16'd7471;
          endcase
        end
      endcase
      return w;
    end
  endfunction

endpackage

[rtl/core/rtg_front.sv]
// Mode decode, channel products and numerator forming, two pipeline stages.
module rtg_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rtg_pkg::ModeW-1:0]   gray_mode_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rtg_pkg::ChanW-1:0]   red_i,
  input  logic [rtg_pkg::ChanW-1:0]   green_i,
  input  logic [rtg_pkg::ChanW-1:0]   blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rtg_pkg::cell_t              out_cell_o
);
  import rtg_pkg::*;

  logic [ChanW-1:0]  chan   [3];
  logic [CoefW-1:0]  coef   [3];
  logic [ProdW-1:0]  prod   [3];
  logic [ProdW-1:0]  prod_q [3];
  luma_kind_e        kind, kind_q;
  logic [ChanW-1:0]  hi, lo, sel;
  logic [ChanW-1:0]  sel_q;
  logic [ChanW+1:0]  sum3, sum3_q;
  logic [ChanW-1:0]  third, third_q;
  logic [ChanW:0]    hl_q;
  logic [ProdW+1:0]  psum;
  logic [20:0]       third_full;
  logic              s1_valid_q, s2_valid_q;
  logic              en1, en2;
  cell_t             cell_d, cell_q;

  assign chan[0] = red_i;
  assign chan[1] = green_i;
  assign chan[2] = blue_i;

  // Each stage loads when it is empty or its transaction moves on.
  assign en2        = !s2_valid_q || out_ready_i;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // Mode decode: weighted modes take a table weight, the Euclidean mode squares.
  always_comb begin
    kind = KIND_AVG;
    sel  = red_i;
    for (int k = 0; k < 3; k++) begin
      coef[k] = '0;
    end
    case (gray_mode_i)
      MODE_BT2020, MODE_BT709, MODE_BT601: begin
        kind = KIND_WSUM;
        for (int k = 0; k < 3; k++) begin
          coef[k] = weight(gray_mode_i, 2'(k));
        end
      end
      MODE_EUCLIDEAN: begin
        kind = KIND_SQRT;
        for (int k = 0; k < 3; k++) begin
          coef[k] = CoefW'(chan[k]);
        end
      end
      MODE_HSL:   kind = KIND_HSL;
      MODE_RED: begin
        kind = KIND_CHAN;
        sel  = red_i;
      end
      MODE_GREEN: begin
        kind = KIND_CHAN;
        sel  = green_i;
      end
      MODE_BLUE: begin
        kind = KIND_CHAN;
        sel  = blue_i;
      end
      default:    kind = KIND_AVG;
    endcase
  end

  // Channel products, extremes and the channel sum for the first stage.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod[k] = ProdW'(chan[k]) * ProdW'(coef[k]);
    end
    hi = red_i;
    lo = red_i;
    if (green_i > hi) hi = green_i;
    if (blue_i  > hi) hi = blue_i;
    if (green_i < lo) lo = green_i;
    if (blue_i  < lo) lo = blue_i;
    sum3 = (ChanW+2)'(red_i) + (ChanW+2)'(green_i) + (ChanW+2)'(blue_i);
    // A third of the sum, exact for sums up to three full channels.
    third_full = 21'(sum3) * 21'd683;
    third      = third_full[18:11];
  end

  // Stage one registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      prod_q  <= prod;
      kind_q  <= kind;
      sel_q   <= sel;
      sum3_q  <= sum3;
      third_q <= third;
      hl_q    <= (ChanW+1)'(hi) + (ChanW+1)'(lo);
    end
  end

  // Numerator over 255 for each kind, or the radicand for the square root.
  always_comb begin
    psum          = (ProdW+2)'(prod_q[0]) + (ProdW+2)'(prod_q[1]) + (ProdW+2)'(prod_q[2]);
    cell_d        = '0;
    case (kind_q)
      KIND_WSUM: cell_d.root = NumW'(psum);
      KIND_SQRT: begin
        cell_d.is_sqrt = 1'b1;
        cell_d.rad     = psum[RadW-1:0];
      end
      KIND_HSL:  cell_d.root = NumW'({hl_q, 15'd0});
      KIND_CHAN: cell_d.root = NumW'({sel_q, 16'd0});
      // Sum times 65536 over 3, split as sum times 21845 plus a third of the sum.
      default:   cell_d.root = NumW'(NumW'(sum3_q) * NumW'(21845)) + NumW'(third_q);
    endcase
  end

  // Stage two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      cell_q <= cell_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_cell_o  = cell_q;

endmodule

[rtl/core/rtg_sqrt_cell.sv]
// One square-root cell: settles one root bit from two radicand bits per transaction.
module rtg_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rtg_pkg::cell_t in_cell_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rtg_pkg::cell_t out_cell_o
);
  import rtg_pkg::*;

  logic              valid_q;
  logic              en;
  logic [RemW+1:0]   cand, trial_sub;
  cell_t             cell_d, cell_q;

  assign en         = !valid_q || out_ready_i;
  assign in_ready_o = en;

  // Restoring step: try to subtract four times the root plus one.
  always_comb begin
    cand      = {in_cell_i.rem, in_cell_i.rad[RadW-1 -: 2]};
    trial_sub = {2'b00, in_cell_i.root, 2'b01};
    cell_d    = in_cell_i;
    if (in_cell_i.is_sqrt) begin
      cell_d.rad = {in_cell_i.rad[RadW-3:0], 2'b00};
      if (cand >= trial_sub) begin
        cell_d.rem  = RemW'(cand - trial_sub);
        cell_d.root = {in_cell_i.root[NumW-2:0], 1'b1};
      end else begin
        cell_d.rem  = cand[RemW-1:0];
        cell_d.root = {in_cell_i.root[NumW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      cell_q <= cell_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_cell_o  = cell_q;

endmodule

[rtl/core/rtg_div255.sv]
// Divide by 255 through a reciprocal multiply and one correction step.
module rtg_div255 (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rtg_pkg::NumW-1:0]  num_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [rtg_pkg::LumaW-1:0] luma_o
);
  import rtg_pkg::*;

  localparam int unsigned QW = NumW - 7;

  logic              s1_valid_q, s2_valid_q;
  logic              en1, en2;
  logic [2*NumW-1:0] prod;
  logic [NumW-1:0]   num_q;
  logic [QW-1:0]     qe_q, q_d;
  logic [NumW:0]     back, rem;
  logic [LumaW-1:0]  luma_q;

  assign en2        = !s2_valid_q || out_ready_i;
  assign en1        = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // Estimate with floor(2^32/255); it falls short of the quotient by at most one.
  assign prod = (2*NumW)'(num_i) * (2*NumW)'(32'h0101_0101);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (en1) s1_valid_q <= in_valid_i;
      if (en2) s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      num_q <= num_i;
      qe_q  <= prod[32 +: QW];
    end
  end

  // Correction: bump the estimate when the remainder reaches 255.
  always_comb begin
    back = {qe_q, 8'd0} - (NumW+1)'(qe_q);
    rem  = (NumW+1)'(num_q) - back;
    q_d  = qe_q;
    if (rem >= (NumW+1)'(255)) begin
      q_d = qe_q + QW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && s1_valid_q) begin
      luma_q <= q_d[LumaW-1:0];
    end
  end

  assign out_valid_o = s2_valid_q;
  assign luma_o      = luma_q;

endmodule

[rtl/core/rgb_to_gray_multimode.sv]
// Stages from input transaction to result: 2 front, 25 root cells, 2 divide.
// Throughput: one pixel per cycle unless stalled; every stage holds one transaction and
// loads when empty or its downstream neighbour takes data; bubbles fill while stalled.
// Reset: asynchronous, active low; clears all valid flags and sets the mode to average.
// The mode register is written through its own channel, which is always ready.
// Top level of the multimode RGB to gray converter.
module rgb_to_gray_multimode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rtg_pkg::ModeW-1:0]   cfg_gray_mode_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rtg_pkg::ChanW-1:0]   red_i,
  input  logic [rtg_pkg::ChanW-1:0]   green_i,
  input  logic [rtg_pkg::ChanW-1:0]   blue_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [rtg_pkg::LumaW-1:0]   luma_o
);
  import rtg_pkg::*;

  logic [ModeW-1:0] gray_mode_q;
  logic             chain_valid [NumCells+1];
  logic             chain_ready [NumCells+1];
  cell_t            chain_cell  [NumCells+1];

  // Mode register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gray_mode_q <= MODE_AVERAGE;
    end else if (cfg_valid_i) begin
      gray_mode_q <= cfg_gray_mode_i;
    end
  end

  // Front stages build the numerator or the radicand.
  rtg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gray_mode_i (gray_mode_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (chain_valid[0]),
    .out_ready_i (chain_ready[0]),
    .out_cell_o  (chain_cell[0])
  );

  // Row of root cells; other modes ride through unchanged.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rtg_sqrt_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (chain_valid[i]),
      .in_ready_o  (chain_ready[i]),
      .in_cell_i   (chain_cell[i]),
      .out_valid_o (chain_valid[i+1]),
      .out_ready_i (chain_ready[i+1]),
      .out_cell_o  (chain_cell[i+1])
    );
  end

  // Final scaling by 1/255.
  rtg_div255 u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (chain_valid[NumCells]),
    .in_ready_o  (chain_ready[NumCells]),
    .num_i       (chain_cell[NumCells].root),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .luma_o      (luma_o)
  );

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the multimode RGB to gray converter.
`timescale 1ns / 100ps

module tb_top;
  import rtg_pkg::*;

  // Cycles without any transaction before the run is abandoned.
  localparam int unsigned QuietLimit = 2000;
  // Long output hold-off, so that the pipeline fills and the input stalls.
  localparam int unsigned LongHold   = 300;
  // Cycles allowed after the last result for a stray one to appear.
  localparam int unsigned TailCycles = 40;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  logic             clk_i           = 1'b0;
  logic             rst_ni          = 1'b0;
  logic             cfg_valid_i     = 1'b0;
  logic             cfg_ready_o;
  logic [ModeW-1:0] cfg_gray_mode_i = '0;
  logic             in_valid_i      = 1'b0;
  logic             in_ready_o;
  logic [ChanW-1:0] red_i           = '0;
  logic [ChanW-1:0] green_i         = '0;
  logic [ChanW-1:0] blue_i          = '0;
  logic             out_valid_o;
  logic             out_ready_i     = 1'b0;
  logic [LumaW-1:0] luma_o;

  rgb_to_gray_multimode u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_gray_mode_i (cfg_gray_mode_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .luma_o          (luma_o)
  );

  // Pixels waiting to be sent, and gray levels waiting to come out.
  pixel_t           pixel_q[$];
  logic [LumaW-1:0] luma_q[$];

  // Mode the converter holds, as the testbench sees it.
  logic [ModeW-1:0] gray_mode = MODE_AVERAGE;

  bit          pixel_taken  = 1'b0;
  bit          idle_on      = 1'b1;
  int unsigned send_gap     = 0;
  int unsigned recv_gap     = 0;
  int unsigned hold_left    = 0;
  int unsigned holds_asked  = 0;
  int unsigned holds_done   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_pixels     = 0;
  int unsigned n_results    = 0;
  int unsigned n_mode_wr    = 0;
  int unsigned n_errors     = 0;

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Integer square root of a value below 2^52, one root bit at a time.
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    begin
      root = 0;
      for (int i = 25; i >= 0; i--) begin
        trial = root | (64'd1 << i);
        if (trial * trial <= v) root = trial;
      end
      return root;
    end
  endfunction

  // Gray level over 255 in Q1.16, truncated, for one pixel in the given mode.
  function automatic logic [LumaW-1:0] gray_level(input logic [ModeW-1:0] mode,
                                                  input pixel_t px);
    int unsigned     r;
    int unsigned     g;
    int unsigned     b;
    int unsigned     hi;
    int unsigned     lo;
    longint unsigned sq;
    longint unsigned level;
    begin
      r = px.red;
      g = px.green;
      b = px.blue;
      hi = (r > g) ? r : g;
      hi = (b > hi) ? b : hi;
      lo = (r < g) ? r : g;
      lo = (b < lo) ? b : lo;
      case (mode)
        MODE_BT2020:    level = (r * 17216 + g * 44434 + b * 3886) / 255;
        MODE_BT709:     level = (r * 13933 + g * 46871 + b * 4732) / 255;
        MODE_BT601:     level = (r * 19595 + g * 38470 + b * 7471) / 255;
        MODE_HSL:       level = ((hi + lo) * 65536) / 510;
        MODE_EUCLIDEAN: begin
          sq = r * r + g * g + b * b;
          level = int_sqrt(sq << 32) / 255;
        end
        MODE_RED:       level = (r * 65536) / 255;
        MODE_GREEN:     level = (g * 65536) / 255;
        MODE_BLUE:      level = (b * 65536) / 255;
        // Average, and every unused code, which behaves as average.
        default:        level = ((r + g + b) * 65536) / 765;
      endcase
      return level[LumaW-1:0];
    end
  endfunction

  // Random pixel, weighted towards channel extremes, grey pixels and ties.
  function automatic pixel_t random_pixel();
    pixel_t      px;
    int unsigned kind;
    begin
      px = 24'($urandom);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        px.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        px.blue  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else if (kind == 1) begin
        px.green = px.red;
        px.blue  = px.red;
      end else if (kind == 2) begin
        px.blue = px.green;
      end
      return px;
    end
  endfunction

  task automatic queue_pixel(input logic [ChanW-1:0] r, input logic [ChanW-1:0] g,
                             input logic [ChanW-1:0] b);
    pixel_t px;
    begin
      px = '{red: r, green: g, blue: b};
      pixel_q.push_back(px);
    end
  endtask

  // The stimulus sequence pauses here until every pixel has gone and every result is back.
  task automatic wait_drained();
    while (pixel_q.size() != 0 || luma_q.size() != 0) @(posedge clk_i);
  endtask

  // Mode writes happen only while the converter is empty.
  task automatic write_mode(input logic [ModeW-1:0] mode);
    @(negedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_gray_mode_i <= mode;
    do @(posedge clk_i); while (!cfg_ready_o);
    gray_mode = mode;
    n_mode_wr++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Sender: presents queued pixels and holds each until its transaction completes.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || pixel_taken) begin
      if (send_gap != 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 11);
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_valid_i <= 1'b1;
        red_i      <= pixel_q[0].red;
        green_i    <= pixel_q[0].green;
        blue_i     <= pixel_q[0].blue;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when one is asked for.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = LongHold - 1;
      out_ready_i <= 1'b0;
    end else if (recv_gap != 0) begin
      recv_gap--;
      out_ready_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      recv_gap = $urandom_range(0, 11);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: predicts each accepted pixel and checks each result in order.
  always @(posedge clk_i) begin
    pixel_t           px;
    logic [LumaW-1:0] want;
    pixel_taken = rst_ni && in_valid_i && in_ready_o;
    if (pixel_taken) begin
      px = '{red: red_i, green: green_i, blue: blue_i};
      luma_q.push_back(gray_level(gray_mode, px));
      void'(pixel_q.pop_front());
      n_pixels++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (luma_q.size() == 0) begin
        $error("luma: result %0d arrived with no pixel outstanding", luma_o);
        n_errors++;
      end else begin
        want = luma_q.pop_front();
        if (luma_o !== want) begin
          $error("luma: expected %0d, actual %0d", want, luma_o);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction of any kind completes.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset mode is average: black, white and a single full channel.
    queue_pixel(8'd0, 8'd0, 8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd255, 8'd0, 8'd0);
    wait_drained();

    // Every defined mode but the average: white, which the Euclidean mode takes above one,
    // and an uneven pixel.
    for (int m = MODE_BT2020; m <= MODE_BLUE; m++) begin
      write_mode(m[ModeW-1:0]);
      queue_pixel(8'd255, 8'd255, 8'd255);
      queue_pixel(8'd1, 8'd128, 8'd254);
      wait_drained();
    end

    // Unused codes fall back to the average.
    write_mode(4'd9);
    queue_pixel(8'd17, 8'd200, 8'd90);
    wait_drained();
    write_mode(4'd15);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd0, 8'd128, 8'd7);
    wait_drained();

    // Random pixels under every mode code, idling switched on and off per phase.
    for (int p = 0; p < 16; p++) begin
      write_mode(p[ModeW-1:0]);
      idle_on = ($urandom_range(0, 3) != 0);
      if (p == 3) holds_asked++;
      repeat (60) pixel_q.push_back(random_pixel());
      wait_drained();
    end

    // Final stretch at full rate on both sides.
    idle_on = 1'b0;
    write_mode(ModeW'($urandom_range(MODE_AVERAGE, MODE_BLUE)));
    repeat (140) pixel_q.push_back(random_pixel());
    wait_drained();

    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d pixels and %0d gray results over %0d mode writes,",
             n_pixels, n_results, n_mode_wr);
    $display("all sixteen mode codes, one long output hold-off and a full-rate stretch.");
    if (n_errors == 0 && luma_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/rtg_pkg.sv
rtl/core/rtg_front.sv
rtl/core/rtg_sqrt_cell.sv
rtl/core/rtg_div255.sv
rtl/core/rgb_to_gray_multimode.sv
verif/tb_top.sv
